// ===== rtl/core/bmh_pkg.sv =====
// Shared types and constants of the binary min-heap priority queue.
// No dependencies; every other file of the block except bmh_ram refers to it by scoped names.
package bmh_pkg;

  localparam int unsigned HEAP_DEPTH   = 256;
  localparam int unsigned KEY_BITS     = 16;
  localparam int unsigned PAYLOAD_BITS = 16;

  // heap index, entry count, and index wide enough for a child position
  localparam int unsigned IDX_W = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned EXT_W = IDX_W + 1;

  localparam int unsigned OP_W = 2;
  localparam int unsigned ST_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PU,
    S_PC,
    S_ROOT,
    S_LAST,
    S_LOAD,
    S_DL,
    S_DR,
    S_DC,
    S_OUT
  } state_e;

endpackage

// ===== rtl/core/bmh_in_if.sv =====
// Request channel of the heap queue: valid/ready plus one operation item.
// Depends on bmh_pkg for field widths.
interface bmh_in_if;
  logic                              valid;
  logic                              ready;
  logic [bmh_pkg::OP_W-1:0]          opcode;
  logic [bmh_pkg::KEY_BITS-1:0]      key;
  logic [bmh_pkg::PAYLOAD_BITS-1:0]  payload;

  modport source (output valid, opcode, key, payload, input ready);
  modport sink   (input valid, opcode, key, payload, output ready);
endinterface

// ===== rtl/core/bmh_out_if.sv =====
// Response channel of the heap queue: valid/ready plus one result item.
// Depends on bmh_pkg for field widths.
interface bmh_out_if;
  logic                              valid;
  logic                              ready;
  logic [bmh_pkg::ST_W-1:0]          status;
  logic [bmh_pkg::KEY_BITS-1:0]      out_key;
  logic [bmh_pkg::PAYLOAD_BITS-1:0]  out_payload;
  logic                              is_empty;
  logic [bmh_pkg::CNT_W-1:0]         entry_count;

  modport source (output valid, status, out_key, out_payload, is_empty, entry_count,
                  input ready);
  modport sink   (input valid, status, out_key, out_payload, is_empty, entry_count,
                  output ready);
endinterface

// ===== rtl/core/binary_min_heap_priority_queue_unit.sv =====
// Top level of the binary min-heap priority queue: sequencer and result register.
// Depends on bmh_pkg, bmh_in_if, bmh_out_if and bmh_ram.
//
//  channel | dir | handshake          | item
//  req_i   | in  | req_i.valid/ready  | opcode, key, payload
//  rsp_o   | out | rsp_o.valid/ready  | status, out_key, out_payload, is_empty, entry_count
//
// One operation at a time; the heap lives in one RAM with registered read data.
// Push: written at once into an empty heap, else each larger parent moves down one level
// until the new entry finds its place. Pop: reads the root and the last entry, then sifts
// the last entry down, the smaller child moving up at each level. Peek reads the root only.
// Full, empty and no-op go straight to the result register.
// Reset clears the entry count; RAM contents need no clearing.
// A result waits in the output register while the next item is taken; the sequencer
// only holds at its last step if that register is still occupied.
module binary_min_heap_priority_queue_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  bmh_in_if.sink           req_i,
  bmh_out_if.source        rsp_o
);

  bmh_pkg::state_e                state_q, state_d;
  bmh_pkg::op_e                   op_q, op_d;
  bmh_pkg::status_e               status_q, status_d;
  logic [bmh_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [bmh_pkg::IDX_W-1:0]      pos_q, pos_d;
  logic [bmh_pkg::IDX_W-1:0]      cidx_q, cidx_d;
  logic                           rv_q, rv_d;
  bmh_pkg::entry_t                ent_q, ent_d;
  bmh_pkg::entry_t                child_q, child_d;
  bmh_pkg::entry_t                res_q, res_d;

  logic                           ov_q, ov_d;
  bmh_pkg::status_e               ostat_q, ostat_d;
  bmh_pkg::entry_t                ores_q, ores_d;
  logic                           oempty_q, oempty_d;
  logic [bmh_pkg::CNT_W-1:0]      ocnt_q, ocnt_d;

  logic                           ram_we;
  logic [bmh_pkg::IDX_W-1:0]      ram_waddr;
  bmh_pkg::entry_t                ram_wdata;
  logic [bmh_pkg::IDX_W-1:0]      ram_raddr;
  bmh_pkg::entry_t                ram_rdata;

  logic [bmh_pkg::IDX_W-1:0]      par_idx;
  logic [bmh_pkg::IDX_W-1:0]      gpar_idx;
  logic [bmh_pkg::EXT_W-1:0]      left_ext;
  logic [bmh_pkg::EXT_W-1:0]      right_ext;
  logic [bmh_pkg::EXT_W-1:0]      cnt_ext;
  logic                           pick_right;
  bmh_pkg::entry_t                sel_ent;
  logic [bmh_pkg::IDX_W-1:0]      sel_idx;
  logic [bmh_pkg::EXT_W-1:0]      next_left;

  bmh_ram #(
    .WIDTH ($bits(bmh_pkg::entry_t)),
    .DEPTH (bmh_pkg::HEAP_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // index arithmetic for the walk
  assign par_idx    = (pos_q - bmh_pkg::IDX_W'(1)) >> 1;
  assign gpar_idx   = (par_idx - bmh_pkg::IDX_W'(1)) >> 1;
  assign left_ext   = {pos_q, 1'b1};
  assign right_ext  = bmh_pkg::EXT_W'(cidx_q) + bmh_pkg::EXT_W'(1);
  assign cnt_ext    = bmh_pkg::EXT_W'(cnt_q);
  // left child wins a tie
  assign pick_right = rv_q && (ram_rdata.key < child_q.key);
  assign sel_ent    = pick_right ? ram_rdata : child_q;
  assign sel_idx    = pick_right ? (cidx_q + bmh_pkg::IDX_W'(1)) : cidx_q;
  assign next_left  = {sel_idx, 1'b1};

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    status_d  = status_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    cidx_d    = cidx_q;
    rv_d      = rv_q;
    ent_d     = ent_q;
    child_d   = child_q;
    res_d     = res_q;
    ov_d      = ov_q && !rsp_o.ready;
    ostat_d   = ostat_q;
    ores_d    = ores_q;
    oempty_d  = oempty_q;
    ocnt_d    = ocnt_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = ent_q;
    ram_raddr = '0;
    req_i.ready = 1'b0;

    unique case (state_q)
      bmh_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d     = bmh_pkg::op_e'(req_i.opcode);
          ent_d    = '{key: req_i.key, payload: req_i.payload};
          res_d    = '0;
          status_d = bmh_pkg::ST_OK;
          state_d  = bmh_pkg::S_OUT;
          unique case (bmh_pkg::op_e'(req_i.opcode)) inside
            bmh_pkg::OP_PUSH: begin
              if (cnt_q == bmh_pkg::CNT_W'(bmh_pkg::HEAP_DEPTH)) begin
                status_d = bmh_pkg::ST_FULL;
              end else begin
                pos_d   = cnt_q[bmh_pkg::IDX_W-1:0];
                state_d = bmh_pkg::S_PU;
              end
            end
            bmh_pkg::OP_POP, bmh_pkg::OP_PEEK: begin
              if (cnt_q == '0) begin
                status_d = bmh_pkg::ST_EMPTY;
              end else begin
                state_d = bmh_pkg::S_ROOT;
              end
            end
            default: begin
              state_d = bmh_pkg::S_OUT;
            end
          endcase
        end
      end

      bmh_pkg::S_PU: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          cnt_d   = cnt_q + bmh_pkg::CNT_W'(1);
          state_d = bmh_pkg::S_OUT;
        end else begin
          ram_raddr = par_idx;
          state_d   = bmh_pkg::S_PC;
        end
      end

      bmh_pkg::S_PC: begin
        ram_we = 1'b1;
        if (ram_rdata.key > ent_q.key) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata;
          pos_d     = par_idx;
          if (par_idx == '0) begin
            state_d = bmh_pkg::S_PU;
          end else begin
            ram_raddr = gpar_idx;
          end
        end else begin
          cnt_d   = cnt_q + bmh_pkg::CNT_W'(1);
          state_d = bmh_pkg::S_OUT;
        end
      end

      bmh_pkg::S_ROOT: begin
        ram_raddr = '0;
        state_d   = bmh_pkg::S_LAST;
      end

      bmh_pkg::S_LAST: begin
        res_d = ram_rdata;
        if (op_q == bmh_pkg::OP_PEEK) begin
          state_d = bmh_pkg::S_OUT;
        end else begin
          cnt_d     = cnt_q - bmh_pkg::CNT_W'(1);
          ram_raddr = cnt_d[bmh_pkg::IDX_W-1:0];
          state_d   = bmh_pkg::S_LOAD;
        end
      end

      bmh_pkg::S_LOAD: begin
        ent_d   = ram_rdata;
        pos_d   = '0;
        state_d = bmh_pkg::S_DL;
      end

      bmh_pkg::S_DL: begin
        if (left_ext >= cnt_ext) begin
          ram_we  = 1'b1;
          state_d = bmh_pkg::S_OUT;
        end else begin
          ram_raddr = left_ext[bmh_pkg::IDX_W-1:0];
          cidx_d    = left_ext[bmh_pkg::IDX_W-1:0];
          state_d   = bmh_pkg::S_DR;
        end
      end

      bmh_pkg::S_DR: begin
        child_d   = ram_rdata;
        rv_d      = right_ext < cnt_ext;
        ram_raddr = right_ext[bmh_pkg::IDX_W-1:0];
        state_d   = bmh_pkg::S_DC;
      end

      bmh_pkg::S_DC: begin
        ram_we = 1'b1;
        if (ent_q.key <= sel_ent.key) begin
          state_d = bmh_pkg::S_OUT;
        end else begin
          // smaller child moves up into the hole
          ram_wdata = sel_ent;
          pos_d     = sel_idx;
          if (next_left < cnt_ext) begin
            ram_raddr = next_left[bmh_pkg::IDX_W-1:0];
            cidx_d    = next_left[bmh_pkg::IDX_W-1:0];
            state_d   = bmh_pkg::S_DR;
          end else begin
            state_d = bmh_pkg::S_DL;
          end
        end
      end

      bmh_pkg::S_OUT: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d     = 1'b1;
          ostat_d  = status_q;
          ores_d   = res_q;
          oempty_d = (cnt_q == '0);
          ocnt_d   = cnt_q;
          state_d  = bmh_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bmh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmh_pkg::S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    cidx_q   <= cidx_d;
    rv_q     <= rv_d;
    ent_q    <= ent_d;
    child_q  <= child_d;
    res_q    <= res_d;
    ostat_q  <= ostat_d;
    ores_q   <= ores_d;
    oempty_q <= oempty_d;
    ocnt_q   <= ocnt_d;
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = ostat_q;
  assign rsp_o.out_key     = ores_q.key;
  assign rsp_o.out_payload = ores_q.payload;
  assign rsp_o.is_empty    = oempty_q;
  assign rsp_o.entry_count = ocnt_q;

endmodule

// ===== rtl/core/bmh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bmh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
